[hdl/stww_pkg.sv]
// stww_pkg: shared types and constants for the scroll tile window wrap point block.
// No dependencies.
package stww_pkg;

  localparam int RING_TILES_DEF = 32;
  localparam int VAL_W = 17;

  localparam logic [5:0] RENDER_W_RST = 6'd31;
  localparam logic [5:0] RENDER_H_RST = 6'd21;
  localparam logic [7:0] MAP_W_RST = 8'd64;
  localparam logic [7:0] MAP_H_RST = 8'd64;

  typedef enum logic [1:0] {
    REG_RENDER_W = 2'd0,
    REG_RENDER_H = 2'd1,
    REG_MAP_W    = 2'd2,
    REG_MAP_H    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GRP_ALL_COLS = 2'd0,
    GRP_NEW_COLS = 2'd1,
    GRP_ALL_ROWS = 2'd2,
    GRP_NEW_ROWS = 2'd3
  } grp_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] value;
    logic [7:0]              divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

endpackage

[hdl/stww_pos_if.sv]
// stww_pos_if: input channel, one camera tile position per word.
// No dependencies.
interface stww_pos_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink (input valid, pos_x, pos_y, output ready);
endinterface

[hdl/stww_desc_if.sv]
// stww_desc_if: output channel, one wrap point descriptor per word.
// No dependencies.
interface stww_desc_if;
  logic       valid;
  logic       ready;
  logic [1:0] group;
  logic [4:0] ring_start;
  logic [4:0] ring_end;
  logic [5:0] ring_wrap_point;
  logic [7:0] map_start;
  logic [7:0] map_end;
  logic [7:0] map_wrap_point;
  logic       last;

  modport source (output valid, group, ring_start, ring_end, ring_wrap_point,
                  map_start, map_end, map_wrap_point, last, input ready);
  modport sink (input valid, group, ring_start, ring_end, ring_wrap_point,
                map_start, map_end, map_wrap_point, last, output ready);
endinterface

[hdl/scroll_tile_window_wrap_points.sv]
// scroll_tile_window_wrap_points: top level, APB registers, sequencer, descriptor mux.
// Depends on stww_pkg, stww_pos_if, stww_desc_if, stww_mod.
//
//   channel  dir  handshake      word
//   pos      in   valid/ready    pos_x, pos_y
//   desc     out  valid/ready    group, ring/map start, end, wrap point, last
//   apb      in   psel/penable   render_width, render_height, map_width, map_height
//
// A moved position runs five remainders, one after another, through the shared
// bit-serial unit (stww_mod), then emits four output words.
// An unchanged position is absorbed with no output.
// pos.ready is low from acceptance until the fourth word is taken; desc stalls hold.
// rst is synchronous; registers return to 31/21/64/64 and no position is held.
module scroll_tile_window_wrap_points
  import stww_pkg::*;
#(
  parameter int RING_TILES = RING_TILES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  stww_pos_if.sink    pos,
  stww_desc_if.source desc
);

  localparam int RB = $clog2(RING_TILES);
  localparam logic [RB:0] RING_VAL = (RB+1)'(RING_TILES);
  localparam logic [2:0] JOB_PX = 3'd0;
  localparam logic [2:0] JOB_PXE = 3'd1;
  localparam logic [2:0] JOB_PY = 3'd2;
  localparam logic [2:0] JOB_PYE = 3'd3;
  localparam logic [2:0] JOB_EY = 3'd4;

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} state_t;

  function automatic logic [4:0] r5(input logic [RB:0] x);
    logic [RB+5:0] e;
    e = (RB+6)'(x);
    return e[4:0];
  endfunction

  function automatic logic [5:0] r6(input logic [RB:0] x);
    logic [RB+5:0] e;
    e = (RB+6)'(x);
    return e[5:0];
  endfunction

  // configuration
  logic [5:0] render_w;
  logic [5:0] render_h;
  logic [7:0] map_w;
  logic [7:0] map_h;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      render_w <= RENDER_W_RST;
      render_h <= RENDER_H_RST;
      map_w    <= MAP_W_RST;
      map_h    <= MAP_H_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_RENDER_W: render_w <= pwdata[5:0];
        REG_RENDER_H: render_h <= pwdata[5:0];
        REG_MAP_W:    map_w <= pwdata[7:0];
        REG_MAP_H:    map_h <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_RENDER_W: prdata = {26'd0, render_w};
      REG_RENDER_H: prdata = {26'd0, render_h};
      REG_MAP_W:    prdata = {24'd0, map_w};
      REG_MAP_H:    prdata = {24'd0, map_h};
      default:      prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t             state;
  logic [2:0]         job;
  logic [1:0]         grp;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic               prev_valid;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic               nx_on, nx_pos, x_still;
  logic               ny_on, ny_pos, y_still;
  logic [7:0]         mres [5];

  mod_req_t mreq;
  mod_rsp_t mrsp;

  logic same;
  assign same = prev_valid && pos.pos_x == prev_x && pos.pos_y == prev_y;

  assign pos.ready = (state == S_IDLE);

  // wide sums
  logic signed [VAL_W-1:0] ex, pxe, ey, pye;
  always_comb begin
    ex  = VAL_W'(px) + $signed({11'd0, render_w});
    pxe = VAL_W'(prev_x) + $signed({11'd0, render_w});
    ey  = VAL_W'(py) + $signed({11'd0, render_h});
    pye = VAL_W'(prev_y) + $signed({11'd0, render_h});
  end

  always_comb begin
    mreq.start = (state == S_START);
    unique case (job)
      JOB_PX: begin
        mreq.value   = VAL_W'(px);
        mreq.divisor = map_w;
      end
      JOB_PXE: begin
        mreq.value   = pxe;
        mreq.divisor = map_w;
      end
      JOB_PY: begin
        mreq.value   = VAL_W'(py);
        mreq.divisor = map_h;
      end
      JOB_PYE: begin
        mreq.value   = pye;
        mreq.divisor = map_h;
      end
      JOB_EY: begin
        mreq.value   = ey;
        mreq.divisor = map_h;
      end
      default: begin
        mreq.value   = '0;
        mreq.divisor = 8'd0;
      end
    endcase
  end

  stww_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      job        <= JOB_PX;
      grp        <= GRP_ALL_COLS;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pos.valid && !same) begin
            px      <= pos.pos_x;
            py      <= pos.pos_y;
            nx_on   <= prev_valid && pos.pos_x != prev_x;
            nx_pos  <= prev_valid && pos.pos_x > prev_x;
            x_still <= prev_valid && pos.pos_x == prev_x;
            ny_on   <= prev_valid && pos.pos_y != prev_y;
            ny_pos  <= prev_valid && pos.pos_y > prev_y;
            y_still <= prev_valid && pos.pos_y == prev_y;
            job     <= JOB_PX;
            state   <= S_START;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mrsp.done) begin
            mres[job] <= mrsp.rem;
            if (job == JOB_EY) begin
              grp   <= GRP_ALL_COLS;
              state <= S_EMIT;
            end else begin
              job   <= job + 3'd1;
              state <= S_START;
            end
          end
        end
        S_EMIT: begin
          if (desc.ready) begin
            if (grp == GRP_NEW_ROWS) begin
              prev_x     <= px;
              prev_y     <= py;
              prev_valid <= 1'b1;
              state      <= S_IDLE;
            end else begin
              grp <= grp + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring spans
  logic [RB-1:0] sxa, exa0, sxn, exn0, sya, eya0, syn, eyn0;
  logic [RB:0]   sxa_o, exa_o, wxa_o, sxn_o, exn_o, wxn_o;
  logic [RB:0]   sya_o, eya_o, wya_o, syn_o, eyn_o, wyn_o;

  always_comb begin
    sxa  = px[RB-1:0];
    exa0 = ex[RB-1:0];
    sxn  = nx_on ? (nx_pos ? pxe[RB-1:0] : sxa) : '0;
    exn0 = nx_on ? (nx_pos ? exa0 : prev_x[RB-1:0]) : '0;
    sya  = py[RB-1:0];
    eya0 = ey[RB-1:0];
    syn  = ny_on ? (ny_pos ? pye[RB-1:0] : sya) : '0;
    eyn0 = ny_on ? (ny_pos ? eya0 : prev_y[RB-1:0]) : '0;

    sxa_o = {1'b0, sxa};
    wxa_o = (exa0 > sxa) ? {1'b0, exa0} : RING_VAL;
    exa_o = (exa0 > sxa) ? '0 : {1'b0, exa0};

    sxn_o = {1'b0, sxn};
    wxn_o = (exn0 > sxn) ? {1'b0, exn0} : RING_VAL;
    exn_o = (exn0 > sxn) ? '0 : {1'b0, exn0};

    sya_o = {1'b0, sya};
    wya_o = (eya0 > sya) ? {1'b0, eya0} : RING_VAL;
    eya_o = (eya0 > sya) ? '0 : {1'b0, eya0};

    syn_o = {1'b0, syn};
    wyn_o = (eyn0 > syn) ? {1'b0, eyn0} : RING_VAL;
    eyn_o = (eyn0 > syn) ? '0 : {1'b0, eyn0};

    // all-rows and new-columns spans blank when the column held still; new rows blank when the row held
    if (x_still) begin
      sya_o = '0;
      eya_o = '0;
      wya_o = '0;
      sxn_o = '0;
      exn_o = '0;
      wxn_o = '0;
    end
    if (y_still) begin
      syn_o = '0;
      eyn_o = '0;
      wyn_o = '0;
    end
  end

  // map spans
  logic [7:0] mxa, mxn, mya, myn, mea, mwa, men, mwn;
  always_comb begin
    mxa = mres[JOB_PX];
    mxn = nx_pos ? mres[JOB_PXE] : mxa;
    mya = mres[JOB_PY];
    myn = ny_pos ? mres[JOB_PYE] : mya;
    mwa = (mres[JOB_EY] > mya) ? mres[JOB_EY] : map_h;
    mea = (mres[JOB_EY] > mya) ? 8'd0 : mres[JOB_EY];
    mwn = (mres[JOB_EY] > myn) ? mres[JOB_EY] : map_h;
    men = (mres[JOB_EY] > myn) ? 8'd0 : mres[JOB_EY];
  end

  assign desc.valid = (state == S_EMIT);
  assign desc.group = grp;
  assign desc.last  = (grp == GRP_NEW_ROWS);

  always_comb begin
    unique case (grp_t'(grp))
      GRP_ALL_COLS: begin
        desc.ring_start      = r5(sxa_o);
        desc.ring_end        = r5(exa_o);
        desc.ring_wrap_point = r6(wxa_o);
        desc.map_start       = mxa;
        desc.map_end         = 8'd0;
        desc.map_wrap_point  = 8'd0;
      end
      GRP_NEW_COLS: begin
        desc.ring_start      = r5(sxn_o);
        desc.ring_end        = r5(exn_o);
        desc.ring_wrap_point = r6(wxn_o);
        desc.map_start       = mxn;
        desc.map_end         = 8'd0;
        desc.map_wrap_point  = 8'd0;
      end
      GRP_ALL_ROWS: begin
        desc.ring_start      = r5(sya_o);
        desc.ring_end        = r5(eya_o);
        desc.ring_wrap_point = r6(wya_o);
        desc.map_start       = mya;
        desc.map_end         = mea;
        desc.map_wrap_point  = mwa;
      end
      GRP_NEW_ROWS: begin
        desc.ring_start      = r5(syn_o);
        desc.ring_end        = r5(eyn_o);
        desc.ring_wrap_point = r6(wyn_o);
        desc.map_start       = myn;
        desc.map_end         = men;
        desc.map_wrap_point  = mwn;
      end
      default: begin
        desc.ring_start      = 5'd0;
        desc.ring_end        = 5'd0;
        desc.ring_wrap_point = 6'd0;
        desc.map_start       = 8'd0;
        desc.map_end         = 8'd0;
        desc.map_wrap_point  = 8'd0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_busy_while_emit: assert property (@(posedge clk) disable iff (rst)
    desc.valid |-> !pos.ready)
    else $error("input taken while descriptors pending");

  a_prev_after_last: assert property (@(posedge clk) disable iff (rst)
    (desc.valid && desc.ready && desc.last) |=> (prev_valid && state == S_IDLE))
    else $error("held position not updated after last word");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && mrsp.done && mreq.divisor != 8'd0) |-> mrsp.rem < mreq.divisor)
    else $error("remainder out of range");
`endif

endmodule

[hdl/stww_mod.sv]
// stww_mod: bit-serial non-negative remainder of a signed value by an 8-bit divisor.
// Depends on stww_pkg. One quotient bit per cycle.
module stww_mod
  import stww_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CW = $clog2(VAL_W);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [VAL_W-1:0] mag;
  logic             neg;
  logic [7:0]       div;
  logic [7:0]       rem;

  logic [8:0] shifted;
  logic [8:0] trial;
  logic [7:0] rem_next;

  always_comb begin
    shifted  = {rem, mag[cnt]};
    trial    = shifted - {1'b0, div};
    rem_next = (shifted >= {1'b0, div}) ? trial[7:0] : shifted[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(VAL_W - 1);
        neg  <= req.value[VAL_W-1];
        mag  <= req.value[VAL_W-1] ? VAL_W'(-req.value) : VAL_W'(req.value);
        div  <= req.divisor;
        rem  <= 8'd0;
      end else if (busy) begin
        rem <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (div == 8'd0) begin
      rsp.rem = 8'd0;
    end else if (neg && rem != 8'd0) begin
      rsp.rem = div - rem;
    end else begin
      rsp.rem = rem;
    end
  end

endmodule

[verif/tb.sv]
// tb: self-checking bench for scroll_tile_window_wrap_points, random positions and config sweep.
// Depends on stww_pkg, stww_pos_if, stww_desc_if and the block itself; expected words are
// predicted in a small scoreboard class and compared field by field on the desc channel.
module tb;
  import stww_pkg::*;

  localparam int RING = RING_TILES_DEF;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 5000;
  localparam int MOVES_PER_PHASE = 68;
  localparam int NUM_PHASES = 7;

  typedef struct {
    grp_t       group;
    logic [4:0] ring_start;
    logic [4:0] ring_end;
    logic [5:0] ring_wrap_point;
    logic [7:0] map_start;
    logic [7:0] map_end;
    logic [7:0] map_wrap_point;
    logic       last;
  } desc_word_t;

  class wrap_point_scoreboard;
    desc_word_t pending_words[$];
    logic [5:0] render_w, render_h;
    logic [7:0] map_w, map_h;
    logic signed [15:0] held_x, held_y;
    bit held_valid;
    int errors, words_checked, frames_moved, frames_still;

    function new();
      render_w = RENDER_W_RST;
      render_h = RENDER_H_RST;
      map_w = MAP_W_RST;
      map_h = MAP_H_RST;
      held_x = '0;
      held_y = '0;
      held_valid = 0;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function void set_register(cfg_reg_t which, logic [31:0] value);
      case (which)
        REG_RENDER_W: render_w = value[5:0];
        REG_RENDER_H: render_h = value[5:0];
        REG_MAP_W: map_w = value[7:0];
        REG_MAP_H: map_h = value[7:0];
      endcase
    endfunction

    function logic [31:0] register_value(cfg_reg_t which);
      case (which)
        REG_RENDER_W: return {26'd0, render_w};
        REG_RENDER_H: return {26'd0, render_h};
        REG_MAP_W: return {24'd0, map_w};
        default: return {24'd0, map_h};
      endcase
    endfunction

    function longint ring_idx(longint v);
      return v & longint'(RING - 1);
    endfunction

    function longint map_idx(longint v, longint m);
      longint r;
      if (m == 0) return 0;
      r = v % m;
      if (r < 0) r += m;
      return r;
    endfunction

    // ring span for the whole window and for the freshly exposed strip of one axis
    function void axis_ring(input longint p, d, len, input bit prior,
                            output longint a_s, a_e, a_w, n_s, n_e, n_w);
      a_s = ring_idx(p);
      a_e = ring_idx(p + len);
      n_s = 0;
      n_e = 0;
      if (prior && d > 0) begin
        n_s = ring_idx(p + len - d);
        n_e = a_e;
      end else if (prior && d < 0) begin
        n_s = a_s;
        n_e = ring_idx(p - d);
      end
      a_w = RING;
      if (a_e > a_s) begin
        a_w = a_e;
        a_e = 0;
      end
      n_w = RING;
      if (n_e > n_s) begin
        n_w = n_e;
        n_e = 0;
      end
    endfunction

    function void push_word(grp_t g, longint rs, re, rw, ms, me, mw);
      desc_word_t w;
      w.group = g;
      w.ring_start = rs[4:0];
      w.ring_end = re[4:0];
      w.ring_wrap_point = rw[5:0];
      w.map_start = ms[7:0];
      w.map_end = me[7:0];
      w.map_wrap_point = mw[7:0];
      w.last = (g == GRP_NEW_ROWS);
      pending_words.push_back(w);
    endfunction

    function void note_position(logic signed [15:0] x, logic signed [15:0] y);
      longint px, py, dx, dy, rw, rh, mw, mh;
      longint cas, cae, caw, cns, cne, cnw, ras, rae, raw, rns, rne, rnw;
      longint mxa, mxn, mya, myn, meya, meyn, mwya, mwyn;
      px = x;
      py = y;
      dx = px - longint'(held_x);
      dy = py - longint'(held_y);
      if (held_valid && dx == 0 && dy == 0) begin
        frames_still++;
        return;
      end
      frames_moved++;
      rw = render_w;
      rh = render_h;
      mw = map_w;
      mh = map_h;

      axis_ring(px, dx, rw, held_valid, cas, cae, caw, cns, cne, cnw);
      mxa = map_idx(px, mw);
      mxn = (held_valid && dx > 0) ? map_idx(px + rw - dx, mw) : mxa;

      axis_ring(py, dy, rh, held_valid, ras, rae, raw, rns, rne, rnw);
      // all-rows span is dropped when the column held, not the row
      if (held_valid && dx == 0) begin
        ras = 0; rae = 0; raw = 0;
      end
      mya = map_idx(py, mh);
      myn = (held_valid && dy > 0) ? map_idx(py + rh - dy, mh) : mya;
      meya = map_idx(py + rh, mh);
      meyn = meya;
      mwya = mh;
      mwyn = mh;
      if (meya > mya) begin
        mwya = meya;
        meya = 0;
      end
      if (meyn > myn) begin
        mwyn = meyn;
        meyn = 0;
      end
      if (held_valid && dy == 0) begin
        rns = 0; rne = 0; rnw = 0;
      end
      if (held_valid && dx == 0) begin
        cns = 0; cne = 0; cnw = 0;
      end

      push_word(GRP_ALL_COLS, cas, cae, caw, mxa, 0, 0);
      push_word(GRP_NEW_COLS, cns, cne, cnw, mxn, 0, 0);
      push_word(GRP_ALL_ROWS, ras, rae, raw, mya, meya, mwya);
      push_word(GRP_NEW_ROWS, rns, rne, rnw, myn, meyn, mwyn);

      held_x = x;
      held_y = y;
      held_valid = 1;
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %0d want %0d", words_checked, name, got, want));
    endtask

    task check_descriptor(desc_word_t got);
      desc_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = pending_words.pop_front();
        check_field("group", 8'(got.group), 8'(want.group));
        check_field("ring_start", 8'(got.ring_start), 8'(want.ring_start));
        check_field("ring_end", 8'(got.ring_end), 8'(want.ring_end));
        check_field("ring_wrap_point", 8'(got.ring_wrap_point), 8'(want.ring_wrap_point));
        check_field("map_start", got.map_start, want.map_start);
        check_field("map_end", got.map_end, want.map_end);
        check_field("map_wrap_point", got.map_wrap_point, want.map_wrap_point);
        check_field("last", 8'(got.last), 8'(want.last));
      end
      words_checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stww_pos_if pos_ch ();
  stww_desc_if desc_ch ();

  wrap_point_scoreboard sb = new();

  bit tx_steady, rx_steady;
  bit hold_off_req, hold_off_done;
  int hold_seen;
  int stall_left;
  int idle_run;
  int phases_run;

  scroll_tile_window_wrap_points dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pos     (pos_ch),
    .desc    (desc_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_position(logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    pos_ch.valid <= 1'b1;
    pos_ch.pos_x <= x;
    pos_ch.pos_y <= y;
    do @(posedge clk); while (!pos_ch.ready);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      pos_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(cfg_reg_t which, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(which, value);
    want = sb.register_value(which);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("reg %s read %0h want %0h", which.name(), prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // the first wait lets the monitor log a word taken at the last edge before the queue is checked
  task automatic settle();
    pos_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sink side: random stalls, plus one long hold-off while the source keeps offering
  initial begin
    int held;
    desc_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        desc_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_seen = held;
        hold_off_done = 1;
      end else if (stall_left > 0) begin
        desc_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        desc_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : monitor
    desc_word_t got;
    if (!rst) begin
      if (pos_ch.valid && pos_ch.ready) sb.note_position(pos_ch.pos_x, pos_ch.pos_y);
      if (desc_ch.valid && desc_ch.ready) begin
        got.group = grp_t'(desc_ch.group);
        got.ring_start = desc_ch.ring_start;
        got.ring_end = desc_ch.ring_end;
        got.ring_wrap_point = desc_ch.ring_wrap_point;
        got.map_start = desc_ch.map_start;
        got.map_end = desc_ch.map_end;
        got.map_wrap_point = desc_ch.map_wrap_point;
        got.last = desc_ch.last;
        sb.check_descriptor(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (pos_ch.valid && pos_ch.ready) || (desc_ch.valid && desc_ch.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_run);
      $display("scroll_tile_window_wrap_points verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int dir_x[20] = '{0, 0, 1, 1, -2, -2, 32767, -32768, 32767, -32768,
                      -1, 31, 0, -64, 100, 21845, -21846, 3, 3, -33};
    int dir_y[20] = '{0, 0, 0, 5, 3, 3, 32767, -32768, -32768, 32767,
                      -1, 20, 0, -64, -100, 10922, -10923, 3, -29, -29};
    int cfg_tab[5][4] = '{'{32, 32, 255, 255}, '{1, 1, 1, 1}, '{0, 0, 0, 0},
                          '{63, 63, 200, 7}, '{31, 21, 64, 64}};
    int cfg_now[4];
    logic signed [15:0] cur_x, cur_y, nx, ny;
    bit have_sent;
    int moves, r, step_x, step_y;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pos_ch.valid <= 1'b0;
    pos_ch.pos_x <= '0;
    pos_ch.pos_y <= '0;
    tx_steady = 0;
    rx_steady = 0;
    hold_off_req = 0;
    hold_off_done = 0;
    hold_seen = 0;
    idle_run = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: first frame, still frames, single-axis moves, extremes, ring and map wrap
    foreach (dir_x[i]) send_position(16'(dir_x[i]), 16'(dir_y[i]));
    cur_x = 16'(dir_x[19]);
    cur_y = 16'(dir_y[19]);
    have_sent = 1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p < 5) begin
        cfg_now = cfg_tab[p];
      end else begin
        cfg_now[0] = $urandom_range(0, 63);
        cfg_now[1] = $urandom_range(0, 63);
        cfg_now[2] = $urandom_range(0, 255);
        cfg_now[3] = $urandom_range(0, 255);
      end
      write_register(REG_RENDER_W, cfg_now[0]);
      write_register(REG_RENDER_H, cfg_now[1]);
      write_register(REG_MAP_W, cfg_now[2]);
      write_register(REG_MAP_H, cfg_now[3]);
      tx_steady = (p % 4 == 1) || (p % 4 == 3);
      rx_steady = (p % 4 == 2) || (p % 4 == 3);
      phases_run++;

      moves = 0;
      while (moves < MOVES_PER_PHASE) begin
        r = $urandom_range(0, 99);
        nx = cur_x;
        ny = cur_y;
        if (r < 60) begin
          step_x = int'($urandom_range(0, 6)) - 3;
          step_y = int'($urandom_range(0, 6)) - 3;
          nx = 16'(cur_x + step_x);
          ny = 16'(cur_y + step_y);
        end else if (r < 72) begin
          // repeat of the held position
        end else if (r < 87) begin
          step_x = int'($urandom_range(0, 80)) - 40;
          if ($urandom_range(0, 1)) nx = 16'(cur_x + step_x);
          else ny = 16'(cur_y + step_x);
        end else begin
          nx = 16'($urandom);
          ny = 16'($urandom);
        end
        if (!have_sent || nx != cur_x || ny != cur_y) moves++;
        if (p == 1 && moves == 10) hold_off_req = 1;
        send_position(nx, ny);
        cur_x = nx;
        cur_y = ny;
        have_sent = 1;
      end
    end

    pos_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d moved and %0d still positions over %0d register settings",
             sb.frames_moved, sb.frames_still, phases_run + 1);
    $display("checked %0d descriptor words, sink hold-off of %0d cycles, %0d mismatches",
             sb.words_checked, hold_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("scroll_tile_window_wrap_points verification clean");
    else
      $display("scroll_tile_window_wrap_points verification failed");
    $finish;
  end
endmodule
